// ===== rtl/edf_pkg.sv =====
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and codes of the earliest-deadline-first task scheduler:
// operation codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package edf_pkg;

    // operation codes of an input transaction
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_CREATE = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_edf_state;

    // commands from controller to datapath
    typedef struct packed {
        logic create;      // load the addressed slot from the input fields
        logic scan_start;  // clear the per-tick search state
        logic rd_en;       // read one slot for the scan
        logic commit;      // run the chosen task and load the result register
    } t_edf_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;    // result register can take a new result this cycle
    } t_edf_status;

endpackage

// ===== rtl/edf_periodic_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler_unit
// Earliest-deadline-first scheduler for periodic tasks with deadline equal
// to period.
// ----------------------------------------------------------------------------
// A create transaction loads one task slot. A tick transaction is accepted
// in S_IDLE; S_SCAN then walks the task table slot by slot through its
// single read port, S_DRAIN finishes the last slot and S_COMMIT runs the
// chosen task and loads the result register. A tick returns one result;
// a create returns none. The result register frees the input side, so the
// next transaction is taken while a result waits; a tick stalls in S_COMMIT
// only while the previous result is still unread.
module edf_periodic_task_scheduler_unit
    import edf_pkg::*;
#(
    parameter int MAX_TASKS  = 8,
    parameter int TIME_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [2:0]  i_task_slot,
    input  logic [15:0] i_exec_budget,
    input  logic [15:0] i_task_period,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_idle,
    output logic [2:0]  o_running_slot,
    output logic        o_switched,
    output logic [15:0] o_remaining_exec,
    output logic [15:0] o_deadline_countdown,
    output logic [15:0] o_release_count,
    output logic        o_deadline_miss
);

    localparam int IDX_W = $clog2(MAX_TASKS);

    t_edf_cmd         cmd;
    t_edf_status      status;
    logic [IDX_W-1:0] rd_addr;

    // sequencer
    edf_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr)
    );

    // task table and result
    edf_datapath #(
        .MAX_TASKS  (MAX_TASKS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_rd_addr            (rd_addr),
        .o_status             (status),
        .i_task_slot          (i_task_slot),
        .i_exec_budget        (i_exec_budget),
        .i_task_period        (i_task_period),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_idle               (o_idle),
        .o_running_slot       (o_running_slot),
        .o_switched           (o_switched),
        .o_remaining_exec     (o_remaining_exec),
        .o_deadline_countdown (o_deadline_countdown),
        .o_release_count      (o_release_count),
        .o_deadline_miss      (o_deadline_miss)
    );

endmodule

// ===== rtl/edf_ctrl.sv =====
// ----------------------------------------------------------------------------
// edf_ctrl
// Sequencer of the scheduler: accepts transactions, walks the slot index
// over the task table on a tick and issues the final commit.
// ----------------------------------------------------------------------------
module edf_ctrl
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_operation,
    output logic                         o_stall,
    input  t_edf_status                  i_status,
    output t_edf_cmd                     o_cmd,
    output logic [$clog2(MAX_TASKS)-1:0] o_rd_addr
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

    t_edf_state       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    // state and scan index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        o_stall   = 1'b1;
        o_cmd     = '0;
        o_rd_addr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_operation == OP_CREATE) begin
                        o_cmd.create = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_idx            = '0;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/edf_datapath.sv =====
// ----------------------------------------------------------------------------
// edf_datapath
// Task table, per-slot tick update, earliest-deadline search and the
// result register of the scheduler.
// ----------------------------------------------------------------------------
module edf_datapath
    import edf_pkg::*;
#(
    parameter int MAX_TASKS  = 8,
    parameter int TIME_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_edf_cmd                     i_cmd,
    input  logic [$clog2(MAX_TASKS)-1:0] i_rd_addr,
    output t_edf_status                  o_status,
    input  logic [2:0]                   i_task_slot,
    input  logic [15:0]                  i_exec_budget,
    input  logic [15:0]                  i_task_period,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_idle,
    output logic [2:0]                   o_running_slot,
    output logic                         o_switched,
    output logic [15:0]                  o_remaining_exec,
    output logic [15:0]                  o_deadline_countdown,
    output logic [15:0]                  o_release_count,
    output logic                         o_deadline_miss
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int TW    = TIME_WIDTH;

    // task table
    logic [TW-1:0] r_mem_period [MAX_TASKS];
    logic [TW-1:0] r_mem_budget [MAX_TASKS];
    logic [TW-1:0] r_mem_left   [MAX_TASKS];
    logic [TW-1:0] r_mem_cd     [MAX_TASKS];
    logic [15:0]   r_mem_rel    [MAX_TASKS];

    logic [TW-1:0] r_rd_period, r_rd_budget, r_rd_left, r_rd_cd;
    logic [15:0]   r_rd_rel;

    // slot flags
    logic [MAX_TASKS-1:0] r_valid, n_valid;
    logic [MAX_TASKS-1:0] r_ready, n_ready;

    // scan pipeline stage
    logic             r_proc_vld;
    logic [IDX_W-1:0] r_proc_idx;

    // search state
    logic             r_best_found, n_best_found;
    logic [IDX_W-1:0] r_best_idx, n_best_idx;
    logic [TW-1:0]    r_best_period, n_best_period;
    logic [TW-1:0]    r_best_budget, n_best_budget;
    logic [TW-1:0]    r_best_left, n_best_left;
    logic [TW-1:0]    r_best_cd, n_best_cd;
    logic [15:0]      r_best_rel, n_best_rel;
    logic             r_miss, n_miss;

    // last task run
    logic             r_last_vld, n_last_vld;
    logic [IDX_W-1:0] r_last_idx, n_last_idx;

    // result register
    logic        r_out_vld, n_out_vld;
    logic        r_out_idle, n_out_idle;
    logic [2:0]  r_out_slot, n_out_slot;
    logic        r_out_sw, n_out_sw;
    logic [15:0] r_out_rem, n_out_rem;
    logic [15:0] r_out_cd, n_out_cd;
    logic [15:0] r_out_rel, n_out_rel;
    logic        r_out_miss, n_out_miss;

    // table write port
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [TW-1:0]    mem_wperiod, mem_wbudget, mem_wleft, mem_wcd;
    logic [15:0]      mem_wrel;

    // create decode
    logic [31:0]      slot_ext;
    logic             slot_in_range;
    logic [IDX_W-1:0] slot_idx;
    logic [47:0]      budget_ext, period_ext;
    logic [TW-1:0]    new_budget, new_period;

    // per-slot update
    logic          p_valid, p_rdy, p_miss, p_cand;
    logic [TW-1:0] p_cd, p_left;

    // commit
    logic          c_sw;
    logic [TW-1:0] c_left;
    logic [15:0]   c_rel;
    logic [47:0]   c_left_ext, c_cd_ext;

    assign o_status.out_free = !r_out_vld || !i_stall;

    // create fields cut or widened to the time width
    always_comb begin
        slot_ext      = {29'd0, i_task_slot};
        slot_in_range = slot_ext < 32'(MAX_TASKS);
        slot_idx      = slot_ext[IDX_W-1:0];
        budget_ext    = {32'd0, i_exec_budget};
        period_ext    = {32'd0, i_task_period};
        new_budget    = budget_ext[TW-1:0];
        new_period    = period_ext[TW-1:0];
    end

    // release, count down and retire one slot
    always_comb begin
        p_valid = r_proc_vld && r_valid[r_proc_idx];
        p_rdy   = r_ready[r_proc_idx];
        p_cd    = r_rd_cd;
        p_left  = r_rd_left;
        p_miss  = 1'b0;
        p_cand  = 1'b0;
        if (!p_rdy) begin
            if (r_rd_cd == '0) begin
                // released: fresh job, then counted down with the ready tasks
                p_rdy  = 1'b1;
                p_left = r_rd_budget;
                if (r_rd_period == '0) begin
                    p_cd   = '0;
                    p_miss = 1'b1;
                end else begin
                    p_cd = r_rd_period - TW'(1);
                end
            end else begin
                p_cd = r_rd_cd - TW'(1);
            end
        end else begin
            if (r_rd_cd == '0) begin
                p_miss = 1'b1;
            end else begin
                p_cd = r_rd_cd - TW'(1);
            end
        end
        // finished job goes back to waiting
        if (p_rdy) begin
            if (p_left == '0) begin
                p_rdy = 1'b0;
            end else begin
                p_cand = 1'b1;
            end
        end
    end

    // run the chosen task
    always_comb begin
        c_sw       = !r_last_vld || (r_last_idx != r_best_idx);
        c_left     = r_best_left - TW'(1);
        c_rel      = (c_sw && (r_best_left == r_best_budget)) ? r_best_rel + 16'd1
                                                              : r_best_rel;
        c_left_ext = {{(48 - TW){1'b0}}, c_left};
        c_cd_ext   = {{(48 - TW){1'b0}}, r_best_cd};
    end

    // next state of flags, search and result
    always_comb begin
        n_valid       = r_valid;
        n_ready       = r_ready;
        n_best_found  = r_best_found;
        n_best_idx    = r_best_idx;
        n_best_period = r_best_period;
        n_best_budget = r_best_budget;
        n_best_left   = r_best_left;
        n_best_cd     = r_best_cd;
        n_best_rel    = r_best_rel;
        n_miss        = r_miss;
        n_last_vld    = r_last_vld;
        n_last_idx    = r_last_idx;
        n_out_vld     = r_out_vld;
        n_out_idle    = r_out_idle;
        n_out_slot    = r_out_slot;
        n_out_sw      = r_out_sw;
        n_out_rem     = r_out_rem;
        n_out_cd      = r_out_cd;
        n_out_rel     = r_out_rel;
        n_out_miss    = r_out_miss;
        mem_we        = 1'b0;
        mem_waddr     = r_proc_idx;
        mem_wperiod   = r_rd_period;
        mem_wbudget   = r_rd_budget;
        mem_wleft     = p_left;
        mem_wcd       = p_cd;
        mem_wrel      = r_rd_rel;

        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        priority if (i_cmd.create) begin
            if (slot_in_range) begin
                n_valid[slot_idx] = 1'b1;
                n_ready[slot_idx] = 1'b1;
                mem_we      = 1'b1;
                mem_waddr   = slot_idx;
                mem_wperiod = new_period;
                mem_wbudget = new_budget;
                mem_wleft   = new_budget;
                mem_wcd     = new_period;
                mem_wrel    = '0;
            end
        end else if (i_cmd.scan_start) begin
            n_best_found = 1'b0;
            n_miss       = 1'b0;
        end else if (i_cmd.commit) begin
            n_out_vld  = 1'b1;
            n_out_miss = r_miss;
            if (r_best_found) begin
                n_out_idle = 1'b0;
                n_out_slot = 3'(r_best_idx);
                n_out_sw   = c_sw;
                n_out_rem  = c_left_ext[15:0];
                n_out_cd   = c_cd_ext[15:0];
                n_out_rel  = c_rel;
                n_last_vld = 1'b1;
                n_last_idx = r_best_idx;
                mem_we      = 1'b1;
                mem_waddr   = r_best_idx;
                mem_wperiod = r_best_period;
                mem_wbudget = r_best_budget;
                mem_wleft   = c_left;
                mem_wcd     = r_best_cd;
                mem_wrel    = c_rel;
            end else begin
                n_out_idle = 1'b1;
                n_out_slot = '0;
                n_out_sw   = 1'b0;
                n_out_rem  = '0;
                n_out_cd   = '0;
                n_out_rel  = '0;
            end
        end else if (p_valid) begin
            // write back the updated slot and keep the earliest deadline
            mem_we              = 1'b1;
            n_ready[r_proc_idx] = p_rdy;
            n_miss              = r_miss || p_miss;
            if (p_cand && (!r_best_found || (p_cd < r_best_cd))) begin
                n_best_found  = 1'b1;
                n_best_idx    = r_proc_idx;
                n_best_period = r_rd_period;
                n_best_budget = r_rd_budget;
                n_best_left   = p_left;
                n_best_cd     = p_cd;
                n_best_rel    = r_rd_rel;
            end
        end else begin
            n_miss = r_miss;
        end
    end

    // task table write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_period[mem_waddr] <= mem_wperiod;
            r_mem_budget[mem_waddr] <= mem_wbudget;
            r_mem_left[mem_waddr]   <= mem_wleft;
            r_mem_cd[mem_waddr]     <= mem_wcd;
            r_mem_rel[mem_waddr]    <= mem_wrel;
        end
        if (i_cmd.rd_en) begin
            r_rd_period <= r_mem_period[i_rd_addr];
            r_rd_budget <= r_mem_budget[i_rd_addr];
            r_rd_left   <= r_mem_left[i_rd_addr];
            r_rd_cd     <= r_mem_cd[i_rd_addr];
            r_rd_rel    <= r_mem_rel[i_rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_ready      <= '0;
            r_proc_vld   <= 1'b0;
            r_best_found <= 1'b0;
            r_miss       <= 1'b0;
            r_last_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_ready      <= n_ready;
            r_proc_vld   <= i_cmd.rd_en;
            r_best_found <= n_best_found;
            r_miss       <= n_miss;
            r_last_vld   <= n_last_vld;
            r_out_vld    <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_proc_idx    <= i_rd_addr;
        r_best_idx    <= n_best_idx;
        r_best_period <= n_best_period;
        r_best_budget <= n_best_budget;
        r_best_left   <= n_best_left;
        r_best_cd     <= n_best_cd;
        r_best_rel    <= n_best_rel;
        r_last_idx    <= n_last_idx;
        r_out_idle    <= n_out_idle;
        r_out_slot    <= n_out_slot;
        r_out_sw      <= n_out_sw;
        r_out_rem     <= n_out_rem;
        r_out_cd      <= n_out_cd;
        r_out_rel     <= n_out_rel;
        r_out_miss    <= n_out_miss;
    end

    assign o_valid              = r_out_vld;
    assign o_idle               = r_out_idle;
    assign o_running_slot       = r_out_slot;
    assign o_switched           = r_out_sw;
    assign o_remaining_exec     = r_out_rem;
    assign o_deadline_countdown = r_out_cd;
    assign o_release_count      = r_out_rel;
    assign o_deadline_miss      = r_out_miss;

    // chosen task is a live ready slot with work left when it runs
    a_best_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_best_found |->
            r_valid[r_best_idx] && r_ready[r_best_idx] && (r_best_left != '0))
        else $error("chosen task is not a ready slot with work left");

    // only created slots can be ready
    a_ready_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready & ~r_valid) == '0)
        else $error("ready flag set on a slot never created");

    // a commit always leaves a result pending
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_vld)
        else $error("commit did not load the result register");

endmodule
